### hdl/stx_etx_dle_deframer_checker_unit_defines.svh
// Assertion macros used by the deframer core.
// No dependencies; each file that asserts includes this header.
`ifndef STX_ETX_DLE_DEFRAMER_CHECKER_UNIT_DEFINES_SVH
`define STX_ETX_DLE_DEFRAMER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEDD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SEDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### hdl/sedd_pkg.sv
// Types, codes and the CRC-16 helper for the STX/ETX/DLE deframer.
// No dependencies.
package sedd_pkg;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REG_CHECKSUM_MODE = 1'b0;
    localparam logic REG_EVENT_NIBBLE  = 1'b1;

    typedef enum logic [1:0] {
        FS_HUNT,
        FS_DATA,
        FS_ESC
    } framer_state_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_CHECK = 3'd1,
        STATUS_SHORT     = 3'd2,
        STATUS_STX_ABORT = 3'd3,
        STATUS_TOO_LONG  = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic          is_frame_end;
        logic [7:0]    data_byte;
        frame_status_t frame_status;
        logic          is_event;
        logic [6:0]    payload_count;
    } result_t;

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hdl/sedd_in_stage.sv
// Input register for received bytes.
// Depends on nothing beyond the clock and reset.
module sedd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

### hdl/sedd_core.sv
// Framing state machine, checksum window, running sum and CRC.
// Depends on sedd_pkg and the assertion macro header.
`include "stx_etx_dle_deframer_checker_unit_defines.svh"

module sedd_core
    import sedd_pkg::*;
#(
    parameter int BUFFER_BYTES = 66
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       checksum_mode,
    input  logic [3:0] event_nibble,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);

    framer_state_t  state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     win0_reg, win0_next;
    logic [7:0]     win1_reg, win1_next;
    logic [7:0]     sum_reg, sum_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     first_reg, first_next;
    logic           mode_reg, mode_next;

    logic           is_stx, is_etx, is_dle;
    logic [CW-1:0]  depth;
    logic [CW-1:0]  released;
    logic           too_long;
    logic           in_window;
    logic           check_good;
    logic           do_start;
    logic           do_collect;
    logic           do_verdict;
    frame_status_t  verdict_status;
    logic           verdict_out;
    logic           byte_out;
    logic           idle_frame;

    assign is_stx    = in_byte == CH_STX;
    assign is_etx    = in_byte == CH_ETX;
    assign is_dle    = in_byte == CH_DLE;
    assign depth     = mode_reg ? CW'(2) : CW'(1);
    assign released  = (count_reg > depth) ? count_reg - depth : '0;
    assign too_long  = count_reg >= CW'(BUFFER_BYTES);
    assign in_window = count_reg < depth;
    assign check_good = mode_reg ? ({win0_reg, win1_reg} == crc_reg)
                                 : ((~sum_reg + 8'd1) == win0_reg);

    always_comb begin
        do_start       = 1'b0;
        do_collect     = 1'b0;
        do_verdict     = 1'b0;
        verdict_status = STATUS_OK;
        if (fire) begin
            case (state_reg)
                FS_HUNT: begin
                    do_start = is_stx;
                end
                FS_ESC: begin
                    do_collect = 1'b1;
                end
                FS_DATA: begin
                    if (is_etx) begin
                        do_verdict = 1'b1;
                        if (count_reg <= depth) begin
                            verdict_status = STATUS_SHORT;
                        end else if (check_good) begin
                            verdict_status = STATUS_OK;
                        end else begin
                            verdict_status = STATUS_BAD_CHECK;
                        end
                    end else if (is_stx) begin
                        do_verdict     = 1'b1;
                        verdict_status = STATUS_STX_ABORT;
                    end else if (!is_dle) begin
                        do_collect = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b0;
                end
            endcase
            if (do_collect && too_long) begin
                do_collect     = 1'b0;
                do_verdict     = 1'b1;
                verdict_status = STATUS_TOO_LONG;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        if (fire) begin
            case (state_reg)
                FS_HUNT: state_next = is_stx ? FS_DATA : FS_HUNT;
                FS_DATA: begin
                    if (do_verdict) begin
                        state_next = FS_HUNT;
                    end else if (is_dle) begin
                        state_next = FS_ESC;
                    end else begin
                        state_next = FS_DATA;
                    end
                end
                FS_ESC:  state_next = do_verdict ? FS_HUNT : FS_DATA;
                default: state_next = FS_HUNT;
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        sum_next   = sum_reg;
        crc_next   = crc_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (do_start || do_verdict) begin
            count_next = '0;
            win0_next  = '0;
            win1_next  = '0;
            sum_next   = '0;
            crc_next   = CRC_INIT;
            first_next = '0;
            mode_next  = checksum_mode;
        end
        if (do_verdict) begin
            res_valid          = 1'b1;
            res.is_frame_end   = 1'b1;
            res.frame_status   = verdict_status;
            res.is_event       = (released != '0) && (first_reg[7:4] == event_nibble);
            res.payload_count  = 7'(released);
        end else if (do_collect) begin
            count_next = count_reg + CW'(1);
            if (in_window) begin
                if (count_reg[0]) begin
                    win1_next = in_byte;
                end else begin
                    win0_next = in_byte;
                end
            end else begin
                if (mode_reg) begin
                    win0_next = win1_reg;
                    win1_next = in_byte;
                end else begin
                    win0_next = in_byte;
                end
                if (count_reg == depth) begin
                    first_next = win0_reg;
                end
                sum_next       = sum_reg + win0_reg;
                crc_next       = crc16_update(crc_reg, win0_reg);
                res_valid      = 1'b1;
                res.data_byte  = win0_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_HUNT;
            count_reg <= '0;
            win0_reg  <= '0;
            win1_reg  <= '0;
            sum_reg   <= '0;
            crc_reg   <= CRC_INIT;
            first_reg <= '0;
            mode_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            win0_reg  <= win0_next;
            win1_reg  <= win1_next;
            sum_reg   <= sum_next;
            crc_reg   <= crc_next;
            first_reg <= first_next;
            mode_reg  <= mode_next;
        end
    end

    assign verdict_out = res_valid && res.is_frame_end;
    assign byte_out    = res_valid && !res.is_frame_end;
    assign idle_frame  = (state_reg == FS_HUNT) && (count_reg == '0);

    `SEDD_ASSERT_IMPLIES(a_count_bounded, aclk, aresetn, 1'b1, count_reg <= CW'(BUFFER_BYTES))
    `SEDD_ASSERT_IMPLIES(a_verdict_no_data, aclk, aresetn, verdict_out, res.data_byte == 8'd0)
    `SEDD_ASSERT_IMPLIES(a_byte_no_status, aclk, aresetn, byte_out, res.frame_status == STATUS_OK)
    `SEDD_ASSERT_IMPLIES(a_byte_no_count, aclk, aresetn, byte_out, res.payload_count == 7'd0)
    `SEDD_ASSERT_NEXT(a_verdict_rehunts, aclk, aresetn, verdict_out, idle_frame)

endmodule

### hdl/sedd_out_stage.sv
// Result register between the deframer core and the result channel.
// Depends on sedd_pkg.
module sedd_out_stage
    import sedd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    res_valid,
    input  result_t res,
    output logic    advance,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign advance = in_valid && (!valid_reg || m_ready);
    assign load    = advance && res_valid;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### hdl/stx_etx_dle_deframer_checker_unit.sv
// Top level of the STX/ETX/DLE deframer and checksum checker.
// Depends on sedd_pkg, sedd_in_stage, sedd_core and sedd_out_stage.
//
// Usage:
// The input channel (s_valid, s_ready, s_rx_byte) takes one raw received
// byte per transaction. The result channel (m_valid, m_ready and the m_
// fields) gives at most one result per input byte: a tentative payload
// byte released from the checksum window, or a frame verdict at ETX or
// on an abort. Bytes outside a frame and bytes held in the window give
// no result.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 selects the checksum, index 1 sets the event nibble.
// The checksum selection is latched when a frame starts.
// An accepted byte is held in the input register and its result in the
// result register; one byte is accepted every cycle while m_ready is high,
// as the framer, window, sum and CRC update together for each byte.
// A synchronous active-low reset returns the framer to hunting for STX,
// empties both registers and restores the configuration defaults.
// When the receiver stalls, the result holds and the input stage keeps
// one more byte before s_ready drops.
module stx_etx_dle_deframer_checker_unit
    import sedd_pkg::*;
#(
    parameter int BUFFER_BYTES = 66
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_frame_end,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_frame_status,
    output logic       m_is_event,
    output logic [6:0] m_payload_count,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    logic       checksum_mode_reg;
    logic [3:0] event_nibble_reg;
    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checksum_mode_reg <= 1'b1;
            event_nibble_reg  <= 4'd14;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CHECKSUM_MODE: checksum_mode_reg <= cfg_data[0];
                REG_EVENT_NIBBLE:  event_nibble_reg  <= cfg_data;
                default:           event_nibble_reg  <= event_nibble_reg;
            endcase
        end
    end

    sedd_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    sedd_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .in_byte       (in_byte),
        .checksum_mode (checksum_mode_reg),
        .event_nibble  (event_nibble_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    sedd_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_is_frame_end  = m_res.is_frame_end;
    assign m_data_byte     = m_res.data_byte;
    assign m_frame_status  = m_res.frame_status;
    assign m_is_event      = m_res.is_event;
    assign m_payload_count = m_res.payload_count;

endmodule
